// File: sv/wmacc_pkg.sv
// shared types and constants of the weighted moment accumulator
package wmacc_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int COUNT_W     = COUNT_BITS + 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(1) << COUNT_BITS;
   localparam logic [16:0] ENTRY_LIMIT_RESET = 17'h10000;

   localparam logic ACTION_POINT = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   // accumulator state after one item, as handed to the back end
   typedef struct packed {
      logic [16:0] count;
      logic [31:0] sum_w;
      logic [47:0] sum_wx;
      logic [47:0] sum_wy;
      logic [63:0] sum_wxx;
      logic [63:0] sum_wyy;
      logic [15:0] min_x;
      logic [15:0] max_x;
      logic [15:0] min_y;
      logic [15:0] max_y;
      logic        limit;
   } snap_type;

   typedef struct packed {
      logic [16:0] count;
      logic [31:0] weight_sum;
      logic [23:0] mean_x;
      logic [23:0] mean_y;
      logic [23:0] rms_x;
      logic [23:0] rms_y;
      logic [15:0] low_x;
      logic [15:0] high_x;
      logic [15:0] low_y;
      logic [15:0] high_y;
      logic        limit;
   } rsp_type;

   typedef struct packed {
      logic     push;
      snap_type data;
   } qwr_type;

endpackage

// File: sv/wmacc_queue.sv
// short snapshot queue between accumulator front end and math back end
module wmacc_queue
   import wmacc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  qwr_type  wr,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output snap_type data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   snap_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 do_pop;

   assign full   = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign valid  = (cnt_ff != '0);
   assign data   = mem_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr.push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!wr.push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (wr.push) begin
         mem_ff[wr_ptr_ff] <= wr.data;
      end
   end

endmodule

// File: sv/wmacc_front.sv
// accumulator front end: squares, weighted sums, extents and entry limit
module wmacc_front
   import wmacc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [15:0] req_sample_x,
   input  logic signed [15:0] req_sample_y,
   input  logic        [15:0] req_weight,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [16:0] csr_entry_limit,
   input  logic               q_full,
   output qwr_type            q_wr
);

   // stage a: registered item and coordinate squares
   logic               a_v_ff, a_v_in;
   logic               a_act_ff;
   logic signed [15:0] a_x_ff, a_y_ff;
   logic        [15:0] a_w_ff;
   logic        [30:0] a_xx_ff, a_yy_ff;
   logic        [15:0] xm, ym;

   // accumulator state
   logic [16:0]        entry_limit_ff;
   logic [16:0]        count_ff, count_in;
   logic [31:0]        sum_w_ff, sum_w_in;
   logic [47:0]        sum_wx_ff, sum_wx_in, sum_wy_ff, sum_wy_in;
   logic [63:0]        sum_wxx_ff, sum_wxx_in, sum_wyy_ff, sum_wyy_in;
   logic signed [15:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [15:0] min_y_ff, min_y_in, max_y_ff, max_y_in;

   logic               adv, take, first, accept;
   logic [16:0]        lim;
   logic signed [32:0] wx, wy;
   logic [46:0]        wxx, wyy;

   assign csr_ready = 1'b1;
   assign adv       = a_v_ff && !q_full;
   assign req_ready = !a_v_ff || adv;
   assign accept    = req_valid && req_ready;

   assign xm = req_sample_x[15] ? 16'(-req_sample_x) : req_sample_x;
   assign ym = req_sample_y[15] ? 16'(-req_sample_y) : req_sample_y;

   assign lim   = (entry_limit_ff > COUNT_CAP) ? COUNT_CAP : entry_limit_ff;
   assign take  = (a_act_ff == ACTION_POINT) && (count_ff < lim);
   assign first = (count_ff == '0);

   assign wx  = $signed({1'b0, a_w_ff}) * a_x_ff;
   assign wy  = $signed({1'b0, a_w_ff}) * a_y_ff;
   assign wxx = {31'b0, a_w_ff} * {16'b0, a_xx_ff};
   assign wyy = {31'b0, a_w_ff} * {16'b0, a_yy_ff};

   always_comb begin
      a_v_in     = accept || (a_v_ff && !adv);
      count_in   = count_ff;
      sum_w_in   = sum_w_ff;
      sum_wx_in  = sum_wx_ff;
      sum_wy_in  = sum_wy_ff;
      sum_wxx_in = sum_wxx_ff;
      sum_wyy_in = sum_wyy_ff;
      min_x_in   = min_x_ff;
      max_x_in   = max_x_ff;
      min_y_in   = min_y_ff;
      max_y_in   = max_y_ff;
      if (a_act_ff == ACTION_CLEAR) begin
         count_in   = '0;
         sum_w_in   = '0;
         sum_wx_in  = '0;
         sum_wy_in  = '0;
         sum_wxx_in = '0;
         sum_wyy_in = '0;
         min_x_in   = '0;
         max_x_in   = '0;
         min_y_in   = '0;
         max_y_in   = '0;
      end else if (take) begin
         count_in   = count_ff + 1'b1;
         sum_w_in   = sum_w_ff + {16'b0, a_w_ff};
         sum_wx_in  = sum_wx_ff + {{15{wx[32]}}, wx};
         sum_wy_in  = sum_wy_ff + {{15{wy[32]}}, wy};
         sum_wxx_in = sum_wxx_ff + {17'b0, wxx};
         sum_wyy_in = sum_wyy_ff + {17'b0, wyy};
         // first point sets both extents
         min_x_in   = (first || a_x_ff < min_x_ff) ? a_x_ff : min_x_ff;
         max_x_in   = (first || a_x_ff > max_x_ff) ? a_x_ff : max_x_ff;
         min_y_in   = (first || a_y_ff < min_y_ff) ? a_y_ff : min_y_ff;
         max_y_in   = (first || a_y_ff > max_y_ff) ? a_y_ff : max_y_ff;
      end
   end

   always_comb begin
      q_wr.push         = adv;
      q_wr.data.count   = count_in;
      q_wr.data.sum_w   = sum_w_in;
      q_wr.data.sum_wx  = sum_wx_in;
      q_wr.data.sum_wy  = sum_wy_in;
      q_wr.data.sum_wxx = sum_wxx_in;
      q_wr.data.sum_wyy = sum_wyy_in;
      q_wr.data.min_x   = min_x_in;
      q_wr.data.max_x   = max_x_in;
      q_wr.data.min_y   = min_y_in;
      q_wr.data.max_y   = max_y_in;
      q_wr.data.limit   = (count_in >= lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff         <= 1'b0;
         entry_limit_ff <= ENTRY_LIMIT_RESET;
         count_ff       <= '0;
         sum_w_ff       <= '0;
         sum_wx_ff      <= '0;
         sum_wy_ff      <= '0;
         sum_wxx_ff     <= '0;
         sum_wyy_ff     <= '0;
         min_x_ff       <= '0;
         max_x_ff       <= '0;
         min_y_ff       <= '0;
         max_y_ff       <= '0;
      end else begin
         a_v_ff <= a_v_in;
         if (csr_valid) begin
            entry_limit_ff <= csr_entry_limit;
         end
         if (adv) begin
            count_ff   <= count_in;
            sum_w_ff   <= sum_w_in;
            sum_wx_ff  <= sum_wx_in;
            sum_wy_ff  <= sum_wy_in;
            sum_wxx_ff <= sum_wxx_in;
            sum_wyy_ff <= sum_wyy_in;
            min_x_ff   <= min_x_in;
            max_x_ff   <= max_x_in;
            min_y_ff   <= min_y_in;
            max_y_ff   <= max_y_in;
         end
      end
      if (accept) begin
         a_act_ff <= req_action;
         a_x_ff   <= req_sample_x;
         a_y_ff   <= req_sample_y;
         a_w_ff   <= req_weight;
         a_xx_ff  <= 31'({15'b0, xm} * {15'b0, xm});
         a_yy_ff  <= 31'({15'b0, ym} * {15'b0, ym});
      end
   end

endmodule

// File: sv/wmacc_back.sv
// math back end: means, rms values by shift-add multiply, root and division
module wmacc_back
   import wmacc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  snap_type q_data,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_MEAN, S_MULA, S_MULB, S_DIFF, S_SQRT, S_RMS, S_DONE
   } state_type;

   state_type    state_ff, state_in;
   logic         axis_ff, axis_in;
   snap_type     snap_ff, snap_in;
   logic         neg_ff, neg_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [55:0]  div_num_ff, div_num_in, div_q_ff, div_q_in;
   logic [31:0]  div_rem_ff, div_rem_in;
   logic [63:0]  mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [95:0]  mul_acc_ff, mul_acc_in, prod_a_ff, prod_a_in;
   logic [111:0] sq_src_ff, sq_src_in;
   logic [57:0]  sq_rem_ff, sq_rem_in;
   logic [55:0]  sq_root_ff, sq_root_in;
   logic [23:0]  mean_x_ff, mean_x_in, mean_y_ff, mean_y_in;
   logic [23:0]  rms_x_ff, rms_x_in, rms_y_ff, rms_y_in;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [47:0]  s1, mag;
   logic [63:0]  s2;
   logic [32:0]  div_t;
   logic         div_ge;
   logic [31:0]  div_rem_nx;
   logic [55:0]  div_q_nx;
   logic [95:0]  mul_acc_nx, diff;
   logic [59:0]  sq_t, sq_trial;
   logic         sq_ge;
   logic [55:0]  sq_root_nx;
   logic [23:0]  q_sat, mean_val, rms_val;
   logic         out_free;

   assign s1  = axis_ff ? snap_ff.sum_wy : snap_ff.sum_wx;
   assign s2  = axis_ff ? snap_ff.sum_wyy : snap_ff.sum_wxx;
   assign mag = s1[47] ? 48'(-s1) : s1;

   assign div_t      = {div_rem_ff, div_num_ff[55]};
   assign div_ge     = (div_t >= {1'b0, snap_ff.sum_w});
   assign div_rem_nx = div_ge ? 32'(div_t - {1'b0, snap_ff.sum_w}) : div_t[31:0];
   assign div_q_nx   = {div_q_ff[54:0], div_ge};

   assign mul_acc_nx = {mul_acc_ff[94:0], 1'b0} + (mul_b_ff[63] ? {32'b0, mul_a_ff} : 96'b0);

   assign diff = (prod_a_ff >= mul_acc_ff) ? prod_a_ff - mul_acc_ff : mul_acc_ff - prod_a_ff;

   assign sq_t       = {sq_rem_ff, sq_src_ff[111:110]};
   assign sq_trial   = {2'b0, sq_root_ff, 2'b01};
   assign sq_ge      = (sq_t >= sq_trial);
   assign sq_root_nx = {sq_root_ff[54:0], sq_ge};

   // mean saturates to the signed 24-bit range
   always_comb begin
      if (neg_ff) begin
         q_sat    = (div_q_nx > 56'h800000) ? 24'h800000 : div_q_nx[23:0];
         mean_val = 24'd0 - q_sat;
      end else begin
         q_sat    = (div_q_nx > 56'h7FFFFF) ? 24'h7FFFFF : div_q_nx[23:0];
         mean_val = q_sat;
      end
      rms_val = (div_q_nx > 56'hFFFFFF) ? 24'hFFFFFF : div_q_nx[23:0];
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      snap_in      = snap_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      div_num_in   = div_num_ff;
      div_q_in     = div_q_ff;
      div_rem_in   = div_rem_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_acc_in   = mul_acc_ff;
      prod_a_in    = prod_a_ff;
      sq_src_in    = sq_src_ff;
      sq_rem_in    = sq_rem_ff;
      sq_root_in   = sq_root_ff;
      mean_x_in    = mean_x_ff;
      mean_y_in    = mean_y_ff;
      rms_x_in     = rms_x_ff;
      rms_y_in     = rms_y_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               snap_in  = q_data;
               axis_in  = 1'b0;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (snap_ff.sum_w == '0) begin
               mean_x_in = '0;
               mean_y_in = '0;
               rms_x_in  = '0;
               rms_y_in  = '0;
               state_in  = S_DONE;
            end else begin
               neg_in     = s1[47];
               div_num_in = {mag, 8'b0};
               div_rem_in = '0;
               div_q_in   = '0;
               cnt_in     = 6'd55;
               state_in   = S_MEAN;
            end
         end
         S_MEAN: begin
            div_rem_in = div_rem_nx;
            div_num_in = {div_num_ff[54:0], 1'b0};
            div_q_in   = div_q_nx;
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (axis_ff) begin
                  mean_y_in = mean_val;
               end else begin
                  mean_x_in = mean_val;
               end
               mul_a_in   = s2;
               mul_b_in   = {32'b0, snap_ff.sum_w};
               mul_acc_in = '0;
               cnt_in     = 6'd63;
               state_in   = S_MULA;
            end
         end
         S_MULA: begin
            mul_acc_in = mul_acc_nx;
            mul_b_in   = {mul_b_ff[62:0], 1'b0};
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               prod_a_in  = mul_acc_nx;
               mul_a_in   = {16'b0, mag};
               mul_b_in   = {16'b0, mag};
               mul_acc_in = '0;
               cnt_in     = 6'd63;
               state_in   = S_MULB;
            end
         end
         S_MULB: begin
            mul_acc_in = mul_acc_nx;
            mul_b_in   = {mul_b_ff[62:0], 1'b0};
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            sq_src_in  = {diff, 16'b0};
            sq_rem_in  = '0;
            sq_root_in = '0;
            cnt_in     = 6'd55;
            state_in   = S_SQRT;
         end
         S_SQRT: begin
            sq_rem_in  = sq_ge ? 58'(sq_t - sq_trial) : sq_t[57:0];
            sq_root_in = sq_root_nx;
            sq_src_in  = {sq_src_ff[109:0], 2'b0};
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               div_num_in = sq_root_nx;
               div_rem_in = '0;
               div_q_in   = '0;
               cnt_in     = 6'd55;
               state_in   = S_RMS;
            end
         end
         S_RMS: begin
            div_rem_in = div_rem_nx;
            div_num_in = {div_num_ff[54:0], 1'b0};
            div_q_in   = div_q_nx;
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (axis_ff) begin
                  rms_y_in = rms_val;
                  state_in = S_DONE;
               end else begin
                  rms_x_in = rms_val;
                  axis_in  = 1'b1;
                  state_in = S_SETUP;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in.count      = snap_ff.count;
               rsp_in.weight_sum = snap_ff.sum_w;
               rsp_in.mean_x     = mean_x_ff;
               rsp_in.mean_y     = mean_y_ff;
               rsp_in.rms_x      = rms_x_ff;
               rsp_in.rms_y      = rms_y_ff;
               rsp_in.low_x      = snap_ff.min_x;
               rsp_in.high_x     = snap_ff.max_x;
               rsp_in.low_y      = snap_ff.min_y;
               rsp_in.high_y     = snap_ff.max_y;
               rsp_in.limit      = snap_ff.limit;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff    <= axis_in;
      snap_ff    <= snap_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
      div_num_ff <= div_num_in;
      div_q_ff   <= div_q_in;
      div_rem_ff <= div_rem_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      mul_acc_ff <= mul_acc_in;
      prod_a_ff  <= prod_a_in;
      sq_src_ff  <= sq_src_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      mean_x_ff  <= mean_x_in;
      mean_y_ff  <= mean_y_in;
      rms_x_ff   <= rms_x_in;
      rms_y_ff   <= rms_y_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// File: sv/weighted_2d_moment_accumulator_core.sv
// weighted 2-d moment accumulator, top level
// Each transfer on req_ carries a weighted point (action 0) or a clear (action 1)
// and yields one transfer on rsp_ with count, weight sum, Q16.8 means and rms
// values and the x/y extents. The front end takes an item per cycle, while the
// queue has room, into a registered accumulate pipeline and writes the updated
// sums into a two-entry queue; the back end works one snapshot at a time through
// a bit-serial sequencer (56-step divider, 64-step shift-add multiplier, 56-step
// square root) and takes no new snapshot until the last result is out. The entry
// limit on csr_ may be written at any idle time and keeps its value on clear.
module weighted_2d_moment_accumulator_core
   import wmacc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [15:0] req_sample_x,
   input  logic signed [15:0] req_sample_y,
   input  logic        [15:0] req_weight,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [16:0] rsp_count,
   output logic        [31:0] rsp_weight_sum,
   output logic signed [23:0] rsp_mean_x,
   output logic signed [23:0] rsp_mean_y,
   output logic        [23:0] rsp_rms_x,
   output logic        [23:0] rsp_rms_y,
   output logic signed [15:0] rsp_low_x,
   output logic signed [15:0] rsp_high_x,
   output logic signed [15:0] rsp_low_y,
   output logic signed [15:0] rsp_high_y,
   output logic               rsp_limit_reached,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [16:0] csr_entry_limit
);

   // queue write side and read side
   qwr_type  q_wr;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   snap_type q_data;
   rsp_type  rsp;

   // front: accumulate and snapshot state after every transfer
   wmacc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .req_weight      (req_weight),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_entry_limit (csr_entry_limit),
      .q_full          (q_full),
      .q_wr            (q_wr)
   );

   // decouples the front end from the long back-end sequence
   wmacc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .data  (q_data)
   );

   // back: means and rms, registered result
   wmacc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_count         = rsp.count;
   assign rsp_weight_sum    = rsp.weight_sum;
   assign rsp_mean_x        = rsp.mean_x;
   assign rsp_mean_y        = rsp.mean_y;
   assign rsp_rms_x         = rsp.rms_x;
   assign rsp_rms_y         = rsp.rms_y;
   assign rsp_low_x         = rsp.low_x;
   assign rsp_high_x        = rsp.high_x;
   assign rsp_low_y         = rsp.low_y;
   assign rsp_high_y        = rsp.high_y;
   assign rsp_limit_reached = rsp.limit;

`ifndef SYNTHESIS
   // front never writes a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_wr.push |-> !q_full)
      else $error("snapshot written into full queue");

   // no weight means no mean and no spread
   a_zero_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_weight_sum == '0) |->
         (rsp_mean_x == '0 && rsp_mean_y == '0 && rsp_rms_x == '0 && rsp_rms_y == '0))
      else $error("nonzero statistics with zero weight sum");

   // count never passes the capped limit
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= COUNT_CAP))
      else $error("point count beyond cap");

   // empty accumulator reports zero extents
   a_empty_extents: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count == '0) |->
         (rsp_low_x == '0 && rsp_high_x == '0 && rsp_low_y == '0 && rsp_high_y == '0))
      else $error("extents set on empty accumulator");
`endif

endmodule
